// File: rtl/mwmt_pkg.sv
// shared constants, types and saturating helpers for the moment tensor core
package mwmt_pkg;

   localparam int MAX_POINTS = 1024;
   localparam int ADDR_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int MASS_W = 32 + $clog2(MAX_POINTS);
   localparam int FRAC_SHIFT = 24;
   localparam int NUM_W = 64 + FRAC_SHIFT;
   localparam int DCNT_W = $clog2(NUM_W + 1);
   localparam int ITEM_W = 128;

   localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

   localparam logic [1:0] PAIR_A [6] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd0, 2'd1};
   localparam logic [1:0] PAIR_B [6] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [ITEM_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } store_req_type;

   typedef struct packed {
      logic              start;
      logic [NUM_W-1:0]  num;
      logic [MASS_W-1:0] den;
   } div_req_type;

   // {overflow, value}
   function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      begin
         s = a + b;
         if (a[63] == b[63] && s[63] != a[63]) begin
            return {1'b1, (a[63] ? S64_MIN : S64_MAX)};
         end
         return {1'b0, s};
      end
   endfunction

   function automatic logic [64:0] sat_neg(input logic [63:0] a);
      begin
         if (a == S64_MIN) begin
            return {1'b1, S64_MAX};
         end
         return {1'b0, 64'd0 - a};
      end
   endfunction

   function automatic logic [63:0] mag64(input logic [63:0] a);
      begin
         return a[63] ? (64'd0 - a) : a;
      end
   endfunction

   // signed 64-bit value from sign and magnitude, saturating
   function automatic logic [64:0] from_mag(input logic neg, input logic [NUM_W-1:0] mag);
      begin
         if (neg) begin
            if (mag > NUM_W'(S64_MIN)) begin
               return {1'b1, S64_MIN};
            end
            return {1'b0, 64'd0 - mag[63:0]};
         end
         if (mag > NUM_W'(S64_MAX)) begin
            return {1'b1, S64_MAX};
         end
         return {1'b0, mag[63:0]};
      end
   endfunction

endpackage

// File: rtl/mass_weighted_moment_tensor_core.sv
// mass-weighted second moment tensor core, top level and sequencer
// loading: one point per cycle; ready stays low from the last point until the result is queued
// after the last point: pass one over all points, centroid by 3 divisions, pass two over all
// points with a pair-product step for each point inside the radius, normalization by 6 divisions
// when mass lies inside, then the inertia step in inertia mode; the divider and multiplier are shared
// synchronous reset clears the sequencer, counts, sums and config; the point store is not cleared
module mass_weighted_moment_tensor_core import mwmt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [127:0]  req_tdata,   // point_mass, pos_x, pos_y, pos_z
   input  logic          req_tlast,   // last_point
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [383:0]  rsp_tdata,   // comp_xx, comp_yy, comp_zz, comp_xy, comp_xz, comp_yz
   output logic [1:0]    rsp_tuser,   // no_mass_inside, overflow_flag
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [3:0]    csr_paddr,
   input  logic [63:0]   csr_pwdata,
   output logic [63:0]   csr_prdata,
   output logic          csr_pready
);

   typedef enum logic [3:0] {
      ST_LOAD, ST_P1_RD, ST_P1_MUL, ST_CEN_GO, ST_CEN_WAIT, ST_P2_RD, ST_P2_DIST,
      ST_P2_PAIR, ST_NRM_GO, ST_NRM_WAIT, ST_INERT, ST_OUT
   } state_type;

   state_type          state_ff, state_in;
   logic [3:0]         step_ff, step_in;
   logic [2:0]         e_ff, e_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               err_ff, err_in;
   logic               nomass_ff, nomass_in;
   logic [63:0]        fsum_ff [3];
   logic [63:0]        fsum_in [3];
   logic [MASS_W-1:0]  mass_ff, mass_in;
   logic [MASS_W-1:0]  mass2_ff, mass2_in;
   logic [63:0]        ssum_ff [6];
   logic [63:0]        ssum_in [6];
   logic [31:0]        cen_ff [3];
   logic [31:0]        cen_in [3];
   logic [63:0]        dist_ff, dist_in;
   logic [63:0]        a_ff, a_in;
   logic [63:0]        hi_ff, hi_in;
   logic [63:0]        term_ff, term_in;
   logic [63:0]        tr_ff, tr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [383:0]       rsp_data_ff, rsp_data_in;
   logic [1:0]         rsp_user_ff, rsp_user_in;
   logic [63:0]        radius_ff;
   logic               mode_ff;

   store_req_type      store_req;
   div_req_type        div_req;
   logic [ITEM_W-1:0]  rd_data;
   logic               div_done;
   logic [NUM_W-1:0]   div_quot;
   logic [31:0]        mul_a, mul_b;
   logic [63:0]        mul_p;

   logic [31:0]        pt_mass;
   logic [31:0]        pos [3];
   logic [31:0]        pmag [3];
   logic               pneg [3];
   logic [32:0]        dval [3];
   logic [32:0]        dnval [3];
   logic [31:0]        dmag [3];
   logic               dneg [3];

   mwmt_store u_store (.clock(clock), .req(store_req), .rd_data(rd_data));
   mwmt_mul u_mul (.clock(clock), .op_a(mul_a), .op_b(mul_b), .prod(mul_p));
   mwmt_div u_div (
      .clock(clock), .reset(reset), .req(div_req), .done(div_done), .quot(div_quot)
   );

   // operand decode from the stored point
   always_comb begin
      pt_mass = rd_data[31:0];
      for (int k = 0; k < 3; k++) begin
         pos[k] = rd_data[32*(k+1) +: 32];
         pneg[k] = pos[k][31];
         pmag[k] = pneg[k] ? (32'd0 - pos[k]) : pos[k];
         dval[k] = {pos[k][31], pos[k]} - {cen_ff[k][31], cen_ff[k]};
         dnval[k] = 33'd0 - dval[k];
         dneg[k] = dval[k][32];
         dmag[k] = dneg[k] ? dnval[k][31:0] : dval[k][31:0];
      end
   end

   always_comb begin
      logic [3:0]   sub2, sub3, sub4, sub8;
      logic [CNT_W-1:0] idx_nx;
      logic         last_pt;
      logic         in_radius;
      logic [64:0]  dsum;
      logic [64:0]  sa;
      logic [64:0]  fm;
      logic [63:0]  term;
      logic [64:0]  wsum;
      logic [63:0]  wmag;
      logic         wneg;
      logic [NUM_W-1:0] q;

      state_in = state_ff;
      step_in = step_ff;
      e_in = e_ff;
      idx_in = idx_ff;
      count_in = count_ff;
      err_in = err_ff;
      nomass_in = nomass_ff;
      fsum_in = fsum_ff;
      mass_in = mass_ff;
      mass2_in = mass2_ff;
      ssum_in = ssum_ff;
      cen_in = cen_ff;
      dist_in = dist_ff;
      a_in = a_ff;
      hi_in = hi_ff;
      term_in = term_ff;
      tr_in = tr_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      mul_a = '0;
      mul_b = '0;
      store_req = '0;
      div_req = '0;

      sub2 = step_ff - 4'd2;
      sub3 = step_ff - 4'd3;
      sub4 = step_ff - 4'd4;
      sub8 = step_ff - 4'd8;
      idx_nx = idx_ff + CNT_W'(1);
      last_pt = (idx_nx == count_ff);
      in_radius = (dist_ff <= radius_ff);
      dsum = {1'b0, dist_ff} + {1'b0, mul_p};
      sa = '0;
      fm = '0;
      term = '0;
      wsum = '0;
      wmag = '0;
      wneg = 1'b0;
      q = div_quot;

      store_req.wr_addr = count_ff[ADDR_W-1:0];
      store_req.wr_data = req_tdata;
      store_req.rd_addr = idx_ff[ADDR_W-1:0];

      unique case (state_ff)
         ST_LOAD: begin
            if (req_tvalid) begin
               if (count_ff < CNT_W'(MAX_POINTS)) begin
                  store_req.wr_en = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  err_in = 1'b1;
               end
               if (req_tlast) begin
                  idx_in = '0;
                  state_in = ST_P1_RD;
               end
            end
         end
         ST_P1_RD: begin
            store_req.rd_en = 1'b1;
            dist_in = '0;
            step_in = '0;
            state_in = ST_P1_MUL;
         end
         ST_P1_MUL: begin
            // squares first, then mass times coordinate
            if (step_ff < 4'd3) begin
               mul_a = pmag[step_ff[1:0]];
               mul_b = pmag[step_ff[1:0]];
            end else if (step_ff < 4'd6) begin
               mul_a = pt_mass;
               mul_b = pmag[sub3[1:0]];
            end
            if (step_ff >= 4'd1 && step_ff <= 4'd3) begin
               dist_in = dsum[64] ? '1 : dsum[63:0];
            end
            if (step_ff >= 4'd4 && in_radius) begin
               term = pneg[sub4[1:0]] ? (64'd0 - mul_p) : mul_p;
               sa = sat_add(fsum_ff[sub4[1:0]], term);
               fsum_in[sub4[1:0]] = sa[63:0];
               err_in = err_ff | sa[64];
               if (step_ff == 4'd4) begin
                  mass_in = mass_ff + MASS_W'(pt_mass);
               end
            end
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd6) begin
               if (!last_pt) begin
                  idx_in = idx_nx;
                  state_in = ST_P1_RD;
               end else if (mass_ff == '0) begin
                  nomass_in = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  e_in = '0;
                  state_in = ST_CEN_GO;
               end
            end
         end
         ST_CEN_GO: begin
            div_req.start = 1'b1;
            div_req.num = NUM_W'(mag64(fsum_ff[e_ff[1:0]]));
            div_req.den = mass_ff;
            state_in = ST_CEN_WAIT;
         end
         ST_CEN_WAIT: begin
            if (div_done) begin
               // clamp the centroid to the signed 32-bit range
               if (fsum_ff[e_ff[1:0]][63]) begin
                  cen_in[e_ff[1:0]] = (q > NUM_W'(33'h0_8000_0000)) ? 32'h8000_0000
                                                                    : 32'd0 - q[31:0];
               end else begin
                  cen_in[e_ff[1:0]] = (q > NUM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
               end
               if (e_ff == 3'd2) begin
                  idx_in = '0;
                  state_in = ST_P2_RD;
               end else begin
                  e_in = e_ff + 3'd1;
                  state_in = ST_CEN_GO;
               end
            end
         end
         ST_P2_RD: begin
            store_req.rd_en = 1'b1;
            dist_in = '0;
            step_in = '0;
            state_in = ST_P2_DIST;
         end
         ST_P2_DIST: begin
            if (step_ff < 4'd3) begin
               mul_a = dmag[step_ff[1:0]];
               mul_b = dmag[step_ff[1:0]];
            end
            if (step_ff >= 4'd1 && step_ff <= 4'd3) begin
               dist_in = dsum[64] ? '1 : dsum[63:0];
            end
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd4) begin
               if (in_radius) begin
                  mass2_in = mass2_ff + MASS_W'(pt_mass);
                  e_in = '0;
                  step_in = '0;
                  state_in = ST_P2_PAIR;
               end else if (!last_pt) begin
                  idx_in = idx_nx;
                  state_in = ST_P2_RD;
               end else begin
                  e_in = '0;
                  state_in = (mass2_ff == '0) ? ST_INERT : ST_NRM_GO;
                  step_in = '0;
               end
            end
         end
         ST_P2_PAIR: begin
            step_in = step_ff + 4'd1;
            priority if (step_ff == 4'd0) begin
               mul_a = dmag[PAIR_A[e_ff]];
               mul_b = dmag[PAIR_B[e_ff]];
            end else if (step_ff == 4'd1) begin
               a_in = mul_p;
               mul_a = pt_mass;
               mul_b = mul_p[63:32];
            end else if (step_ff == 4'd2) begin
               hi_in = mul_p;
               mul_a = pt_mass;
               mul_b = a_ff[31:0];
            end else if (step_ff == 4'd3) begin
               // (m * a) >> 24 from the high and low halves, saturating
               wsum = {1'b0, hi_ff[55:0], 8'd0} + 65'(mul_p[63:FRAC_SHIFT]);
               if (hi_ff[63:56] != '0 || wsum[64]) begin
                  wmag = '1;
               end else begin
                  wmag = wsum[63:0];
               end
               wneg = (dneg[PAIR_A[e_ff]] ^ dneg[PAIR_B[e_ff]]) && (a_ff != '0);
               fm = from_mag(wneg, NUM_W'(wmag));
               term_in = fm[63:0];
               err_in = err_ff | fm[64];
            end else begin
               sa = sat_add(ssum_ff[e_ff], term_ff);
               ssum_in[e_ff] = sa[63:0];
               err_in = err_ff | sa[64];
               step_in = '0;
               if (e_ff != 3'd5) begin
                  e_in = e_ff + 3'd1;
               end else if (!last_pt) begin
                  idx_in = idx_nx;
                  state_in = ST_P2_RD;
               end else begin
                  e_in = '0;
                  state_in = (mass2_in == '0) ? ST_INERT : ST_NRM_GO;
               end
            end
         end
         ST_NRM_GO: begin
            div_req.start = 1'b1;
            div_req.num = {mag64(ssum_ff[e_ff]), FRAC_SHIFT'(0)};
            div_req.den = mass2_ff;
            state_in = ST_NRM_WAIT;
         end
         ST_NRM_WAIT: begin
            if (div_done) begin
               fm = from_mag(ssum_ff[e_ff][63], q);
               ssum_in[e_ff] = fm[63:0];
               err_in = err_ff | fm[64];
               if (e_ff == 3'd5) begin
                  step_in = '0;
                  state_in = ST_INERT;
               end else begin
                  e_in = e_ff + 3'd1;
                  state_in = ST_NRM_GO;
               end
            end
         end
         ST_INERT: begin
            // in inertia mode: trace, then negate all six, then add trace on the diagonal
            step_in = step_ff + 4'd1;
            if (!mode_ff) begin
               state_in = ST_OUT;
            end else begin
               priority if (step_ff == 4'd0) begin
                  sa = sat_add(ssum_ff[0], ssum_ff[1]);
                  tr_in = sa[63:0];
                  err_in = err_ff | sa[64];
               end else if (step_ff == 4'd1) begin
                  sa = sat_add(tr_ff, ssum_ff[2]);
                  tr_in = sa[63:0];
                  err_in = err_ff | sa[64];
               end else if (step_ff <= 4'd7) begin
                  sa = sat_neg(ssum_ff[sub2[2:0]]);
                  ssum_in[sub2[2:0]] = sa[63:0];
                  err_in = err_ff | sa[64];
               end else begin
                  sa = sat_add(tr_ff, ssum_ff[sub8[2:0]]);
                  ssum_in[sub8[2:0]] = sa[63:0];
                  err_in = err_ff | sa[64];
                  if (step_ff == 4'd10) begin
                     state_in = ST_OUT;
                  end
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               for (int e = 0; e < 6; e++) begin
                  rsp_data_in[64*e +: 64] = ssum_ff[e];
               end
               rsp_user_in = {err_ff, nomass_ff};
               count_in = '0;
               err_in = 1'b0;
               nomass_in = 1'b0;
               mass_in = '0;
               mass2_in = '0;
               for (int k = 0; k < 3; k++) begin
                  fsum_in[k] = '0;
               end
               for (int e = 0; e < 6; e++) begin
                  ssum_in[e] = '0;
               end
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cen_ff <= cen_in;
      dist_ff <= dist_in;
      a_ff <= a_in;
      hi_ff <= hi_in;
      term_ff <= term_in;
      tr_ff <= tr_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      step_ff <= step_in;
      e_ff <= e_in;
      idx_ff <= idx_in;
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         err_ff <= 1'b0;
         nomass_ff <= 1'b0;
         mass_ff <= '0;
         mass2_ff <= '0;
         for (int k = 0; k < 3; k++) begin
            fsum_ff[k] <= '0;
         end
         for (int e = 0; e < 6; e++) begin
            ssum_ff[e] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         err_ff <= err_in;
         nomass_ff <= nomass_in;
         mass_ff <= mass_in;
         mass2_ff <= mass2_in;
         fsum_ff <= fsum_in;
         ssum_ff <= ssum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // configuration registers, paddr[3] selects the register
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0;
         mode_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr[3]) begin
            mode_ff <= csr_pwdata[0];
         end else begin
            radius_ff <= csr_pwdata;
         end
      end
   end

   assign csr_prdata = csr_paddr[3] ? {63'd0, mode_ff} : radius_ff;
   assign csr_pready = 1'b1;
   assign req_tready = (state_ff == ST_LOAD);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

endmodule

// File: rtl/mwmt_store.sv
// point store, one write and one registered read port
module mwmt_store import mwmt_pkg::*; (
   input  logic              clock,
   input  store_req_type     req,
   output logic [ITEM_W-1:0] rd_data
);

   logic [ITEM_W-1:0] mem_ff [MAX_POINTS];
   logic [ITEM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem_ff[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem_ff[req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/mwmt_mul.sv
// shared 32x32 unsigned multiplier with registered product
module mwmt_mul import mwmt_pkg::*; (
   input  logic        clock,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic [63:0] prod
);

   logic [63:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= 64'(op_a) * 64'(op_b);
   end

   assign prod = prod_ff;

endmodule

// File: rtl/mwmt_div.sv
// restoring unsigned divider, one quotient bit per cycle
module mwmt_div import mwmt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  div_req_type      req,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   logic [NUM_W-1:0]  num_ff, num_in;
   logic [MASS_W-1:0] rem_ff, rem_in;
   logic [MASS_W-1:0] den_ff, den_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [MASS_W:0]   shifted;
   logic [MASS_W:0]   diff;

   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      shifted = {rem_ff, num_ff[NUM_W-1]};
      diff = shifted - {1'b0, den_ff};
      if (req.start) begin
         num_in = req.num;
         den_in = req.den;
         rem_in = '0;
         cnt_in = DCNT_W'(NUM_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = diff[MASS_W-1:0];
            num_in = {num_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[MASS_W-1:0];
            num_in = {num_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - DCNT_W'(1);
         if (cnt_ff == DCNT_W'(1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = num_ff;

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the mass-weighted moment tensor core
module tb_top;
   import mwmt_pkg::*;

   localparam int STORE_DEPTH = MAX_POINTS;
   localparam int IDLE_LIMIT = 200000;
   localparam logic [3:0] ADDR_RADIUS_SQ = 4'd0;
   localparam logic [3:0] ADDR_TENSOR_MODE = 4'd8;
   localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint I64_MIN = 64'sh8000_0000_0000_0000;

   typedef struct packed {
      logic [383:0] tensor;
      logic [1:0]   flags;    // overflow, no mass inside
   } tensor_result_type;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [127:0]  req_tdata;   // point_mass, pos_x, pos_y, pos_z
   logic          req_tlast;   // last_point
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [383:0]  rsp_tdata;   // comp_xx, comp_yy, comp_zz, comp_xy, comp_xz, comp_yz
   logic [1:0]    rsp_tuser;   // no_mass_inside, overflow_flag
   logic          csr_psel;
   logic          csr_penable;
   logic          csr_pwrite;
   logic [3:0]    csr_paddr;
   logic [63:0]   csr_pwdata;
   logic [63:0]   csr_prdata;
   logic          csr_pready;

   mass_weighted_moment_tensor_core dut (.*);

   // predictor state
   int unsigned    mass_mem [STORE_DEPTH];
   int             pos_mem [STORE_DEPTH][3];
   int unsigned    loaded_count;
   bit             sat_latch;
   logic [63:0]    radius_sq_reg;
   bit             inertia_mode;

   tensor_result_type expected_tensors [$];
   int             mismatch_count;
   int             items_sent;
   bit             tx_calm;
   bit             rx_calm;
   bit             rx_hold_req;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [63:0] mag_u(longint v);
      return v < 0 ? 64'd0 - 64'(v) : 64'(v);
   endfunction

   function automatic longint sadd(longint a, longint b);
      if (b > 0 && a > I64_MAX - b) begin
         sat_latch = 1'b1;
         return I64_MAX;
      end
      if (b < 0 && a < I64_MIN - b) begin
         sat_latch = 1'b1;
         return I64_MIN;
      end
      return a + b;
   endfunction

   function automatic longint sneg(longint a);
      if (a == I64_MIN) begin
         sat_latch = 1'b1;
         return I64_MAX;
      end
      return -a;
   endfunction

   function automatic longint signed_of_mag(bit neg, logic [63:0] m);
      logic [63:0] lim;
      lim = 64'h8000_0000_0000_0000;
      if (neg) begin
         if (m > lim) begin
            sat_latch = 1'b1;
            m = lim;
         end
         return m == lim ? I64_MIN : -longint'(m);
      end
      if (m > 64'(I64_MAX)) begin
         sat_latch = 1'b1;
         return I64_MAX;
      end
      return longint'(m);
   endfunction

   // squared distance, saturating without a flag; each square wraps at 64 bits
   function automatic logic [63:0] squared_dist(longint dx, longint dy, longint dz);
      logic [63:0] s, a, q;
      longint d [3];
      d[0] = dx; d[1] = dy; d[2] = dz;
      s = 64'd0;
      for (int k = 0; k < 3; k++) begin
         a = mag_u(d[k]);
         q = a * a;
         if (s > U64_MAX - q) return U64_MAX;
         s = s + q;
      end
      return s;
   endfunction

   function automatic logic [63:0] mass_scaled(logic [31:0] m, logic [63:0] a);
      logic [63:0] hi, lo;
      hi = {32'd0, m} * {32'd0, a[63:32]};
      lo = ({32'd0, m} * {32'd0, a[31:0]}) >> 24;
      if (hi > (U64_MAX >> 8)) return U64_MAX;
      hi = hi << 8;
      if (hi > U64_MAX - lo) return U64_MAX;
      return hi + lo;
   endfunction

   function automatic longint normalize(longint acc, logic [63:0] den);
      logic [63:0] m, q, r;
      m = mag_u(acc);
      q = m / den;
      r = m % den;
      for (int i = 0; i < 24; i++) begin
         if (q[63]) begin
            q = U64_MAX;
            break;
         end
         q = q << 1;
         r = r << 1;
         if (r >= den) begin
            r = r - den;
            q[0] = 1'b1;
         end
      end
      return signed_of_mag(acc < 0, q);
   endfunction

   // load one point; on the last point compute the tensor and queue it
   task automatic predict_point(logic [31:0] m, logic [31:0] x, logic [31:0] y,
                                logic [31:0] z, bit last);
      longint fm [3];
      longint sm [6];
      longint res [6];
      longint cen [3];
      longint d [3];
      longint v, tr;
      logic [63:0] mtot, mass2, a;
      int pa [6];
      int pb [6];
      bit neg;
      tensor_result_type r;
      pa = '{0, 1, 2, 0, 0, 1};
      pb = '{0, 1, 2, 1, 2, 2};
      if (loaded_count < STORE_DEPTH) begin
         mass_mem[loaded_count] = m;
         pos_mem[loaded_count] = '{int'(x), int'(y), int'(z)};
         loaded_count++;
      end else begin
         sat_latch = 1'b1;
      end
      if (!last) return;
      fm = '{0, 0, 0};
      sm = '{0, 0, 0, 0, 0, 0};
      res = '{0, 0, 0, 0, 0, 0};
      mtot = 64'd0;
      mass2 = 64'd0;
      for (int n = 0; n < loaded_count; n++) begin
         if (squared_dist(pos_mem[n][0], pos_mem[n][1], pos_mem[n][2]) > radius_sq_reg)
            continue;
         for (int k = 0; k < 3; k++)
            fm[k] = sadd(fm[k], longint'(mass_mem[n]) * longint'(pos_mem[n][k]));
         mtot = mtot + 64'(mass_mem[n]);
      end
      if (mtot != 0) begin
         for (int k = 0; k < 3; k++) begin
            v = fm[k] / longint'(mtot);
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            cen[k] = v;
         end
         for (int n = 0; n < loaded_count; n++) begin
            for (int k = 0; k < 3; k++) d[k] = longint'(pos_mem[n][k]) - cen[k];
            if (squared_dist(d[0], d[1], d[2]) > radius_sq_reg) continue;
            mass2 = mass2 + 64'(mass_mem[n]);
            for (int e = 0; e < 6; e++) begin
               a = mag_u(d[pa[e]]) * mag_u(d[pb[e]]);
               neg = ((d[pa[e]] < 0) != (d[pb[e]] < 0)) && a != 0;
               sm[e] = sadd(sm[e], signed_of_mag(neg, mass_scaled(mass_mem[n], a)));
            end
         end
         if (mass2 > 0)
            for (int e = 0; e < 6; e++) res[e] = normalize(sm[e], mass2);
         if (inertia_mode) begin
            tr = sadd(sadd(res[0], res[1]), res[2]);
            for (int e = 0; e < 3; e++) res[e] = sadd(tr, sneg(res[e]));
            for (int e = 3; e < 6; e++) res[e] = sneg(res[e]);
         end
      end
      for (int e = 0; e < 6; e++) r.tensor[64*e +: 64] = 64'(res[e]);
      r.flags = {sat_latch, mtot == 0};
      expected_tensors.push_back(r);
      loaded_count = 0;
      sat_latch = 1'b0;
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   // result checker
   always @(posedge clock) begin
      tensor_result_type want;
      string names [6];
      names = '{"comp_xx", "comp_yy", "comp_zz", "comp_xy", "comp_xz", "comp_yz"};
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_tensors.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_tdata[63:0], 64'd0);
         end else begin
            want = expected_tensors.pop_front();
            for (int e = 0; e < 6; e++)
               if (rsp_tdata[64*e +: 64] !== want.tensor[64*e +: 64])
                  report_mismatch(names[e], rsp_tdata[64*e +: 64], want.tensor[64*e +: 64]);
            if (rsp_tuser[0] !== want.flags[0])
               report_mismatch("no_mass_inside", 64'(rsp_tuser[0]), 64'(want.flags[0]));
            if (rsp_tuser[1] !== want.flags[1])
               report_mismatch("overflow_flag", 64'(rsp_tuser[1]), 64'(want.flags[1]));
         end
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      int hold_left;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            hold_left = 3000;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= rx_calm || ($urandom_range(99) >= 14);
         end
      end
   end

   // watchdog on cycles with no transaction anywhere
   always @(posedge clock) begin
      int quiet;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   task automatic send_point(logic [31:0] m, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z, bit last);
      if (!tx_calm && $urandom_range(99) < 14) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {z, y, x, m};
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_point(m, x, y, z, last);
      items_sent++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_tensors.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic [3:0] addr, logic [63:0] data);
      drain_results();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (addr == ADDR_RADIUS_SQ) radius_sq_reg = data;
      else if (addr == ADDR_TENSOR_MODE) inertia_mode = data[0];
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   function automatic logic [31:0] coord_within(logic [31:0] span);
      if (span[31]) return $urandom();
      return $urandom_range(2 * span) - span;
   endfunction

   function automatic logic [31:0] random_mass();
      case ($urandom_range(5))
         0: return 32'd0;
         1: return $urandom_range(255);
         2: return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   task automatic test_basic_sets();
      for (int md = 0; md < 2; md++) begin
         csr_write(ADDR_TENSOR_MODE, {$urandom(), 31'($urandom()), 1'b0} | 64'(md));
         csr_write(ADDR_RADIUS_SQ, U64_MAX);
         send_point(32'h0100_0000, 32'd0, 32'd0, 32'd0, 1'b1);
         send_point(32'h0100_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 1'b0);
         send_point(32'h0080_0000, 32'hFFFF_0000, 32'h0001_0000, 32'hFFFE_0000, 1'b0);
         send_point(32'h0200_0000, 32'h0003_8000, 32'h0000_4000, 32'hFFFF_C000, 1'b1);
      end
   endtask

   task automatic test_extremes();
      csr_write(ADDR_TENSOR_MODE, 64'd1);
      send_point(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      send_point(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      send_point(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
      // zero total mass
      send_point(32'd0, 32'h0001_0000, 32'd0, 32'd0, 1'b1);
      // radius zero: nothing off the origin counts
      csr_write(ADDR_RADIUS_SQ, 64'd0);
      send_point(32'h0100_0000, 32'd1, 32'd0, 32'd0, 1'b0);
      send_point(32'h0100_0000, 32'd0, 32'd0, 32'd0, 1'b1);
      send_point(32'h0100_0000, 32'd0, 32'd0, 32'd1, 1'b1);
      // boundary is inclusive
      csr_write(ADDR_RADIUS_SQ, 64'h0001_0000_0000);
      csr_write(ADDR_TENSOR_MODE, 64'd0);
      send_point(32'h0100_0000, 32'h0001_0000, 32'd0, 32'd0, 1'b0);
      send_point(32'h0100_0000, 32'hFFFF_0000, 32'd0, 32'd0, 1'b0);
      send_point(32'h0100_0000, 32'd0, 32'h0001_0001, 32'd0, 1'b1);
   endtask

   // one set past the store size; the dropped last point still closes the set
   task automatic test_store_full();
      csr_write(ADDR_RADIUS_SQ, U64_MAX);
      tx_calm = 1'b1;
      for (int n = 0; n < STORE_DEPTH + 6; n++)
         send_point($urandom_range(32'h0100_0000), coord_within(32'h0010_0000),
                    coord_within(32'h0010_0000), coord_within(32'h0010_0000),
                    n == STORE_DEPTH + 5);
      tx_calm = 1'b0;
   endtask

   task automatic random_set(logic [31:0] span);
      int len;
      len = $urandom_range(99) < 85 ? $urandom_range(1, 8) : $urandom_range(9, 30);
      for (int n = 0; n < len; n++)
         send_point(random_mass(), coord_within(span), coord_within(span),
                    coord_within(span), n == len - 1);
   endtask

   task automatic test_backpressure();
      rx_hold_req = 1'b1;
      tx_calm = 1'b1;
      for (int s = 0; s < 4; s++) random_set(32'h0004_0000);
      tx_calm = 1'b0;
   endtask

   task automatic test_random_sets();
      logic [31:0] span;
      logic [31:0] r;
      int sets_left;
      sets_left = 0;
      while (items_sent < 1950) begin
         if (sets_left == 0) begin
            case ($urandom_range(3))
               0: span = 32'h0000_0100;
               1: span = 32'h0001_0000;
               2: span = 32'h0100_0000;
               default: span = 32'h8000_0000;
            endcase
            r = span[31] ? $urandom() : $urandom_range(2 * span);
            case ($urandom_range(5))
               0: csr_write(ADDR_RADIUS_SQ, U64_MAX);
               1: csr_write(ADDR_RADIUS_SQ, {$urandom(), $urandom()});
               default: csr_write(ADDR_RADIUS_SQ, {32'd0, r} * {32'd0, r});
            endcase
            csr_write(ADDR_TENSOR_MODE, {$urandom(), $urandom()});
            rx_calm = $urandom_range(7) == 0;
            tx_calm = rx_calm;
            sets_left = $urandom_range(5, 25);
         end
         random_set(span);
         sets_left--;
      end
      rx_calm = 1'b0;
      tx_calm = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      loaded_count = 0;
      sat_latch = 1'b0;
      radius_sq_reg = 64'd0;
      inertia_mode = 1'b0;
      mismatch_count = 0;
      items_sent = 0;
      tx_calm = 1'b0;
      rx_calm = 1'b0;
      rx_hold_req = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_sets();
      test_extremes();
      test_backpressure();
      test_store_full();
      test_random_sets();
      drain_results();
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && expected_tensors.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
